// ===== hw/rtl/sqvs_pkg.sv =====
// Shared types, constants and the sine table builder for the sprite quad vertex setup.
`timescale 1ns / 1ps

package sqvs_pkg;

    // Block sizing
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int TEXTURE_SLOTS    = 8;

    // Field widths
    localparam int COORD_W = 24;   // Q16.8 positions and sizes
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 16;
    localparam int TEX_W   = 18;   // Q2.16 texture coordinates
    localparam int SLOT_W  = 3;

    // Rotation datapath widths
    localparam int SINE_W = 17;               // table magnitude, 0..65536
    localparam int TRIG_W = SINE_W + 1;       // signed sine / cosine
    localparam int LOC_W  = COORD_W + 1;      // corner offset from the pivot
    localparam int PROD_W = LOC_W + TRIG_W;   // one rotation product
    localparam int ACC_W  = PROD_W + 1;       // sum of two products plus rounding
    localparam int ROT_W  = ACC_W - 16;       // rotated offset, back in Q.8
    localparam int SUM_W  = ROT_W + 1;        // destination plus rotated offset

    // Sine table addressing
    localparam int SIN_IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PHASE_PROD_W = 14 + SIN_IDX_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [SINE_W-1:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    // Per-vertex attributes that ride along with the rotation pipeline
    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic [COLOR_W-1:0]        alpha;
        logic [TEX_W-1:0]          tex_u;
        logic [TEX_W-1:0]          tex_v;
        logic [SLOT_W-1:0]         slot;
        logic                      last;
    } t_vtx_attr;

    // Quarter-wave sine in Q1.16, Taylor series of 8 terms in Q30,
    // evaluated at elaboration.
    function automatic t_sine_rom f_build_sine();
        t_sine_rom          rom;
        logic [63:0]        theta;
        logic [63:0]        term;
        logic [63:0]        s;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            theta = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
            term  = theta;
            sum   = signed'(theta);
            for (int n = 1; n <= 7; n++) begin
                term = (((term * theta) >> 30) * theta) >> 30;
                case (n)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    6:       term = term / 156;
                    default: term = term / 210;
                endcase
                if ((n % 2) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            s = (unsigned'(sum) + 64'd8192) >> 14;
            if (s > 64'd65536) begin
                s = 64'd65536;
            end
            rom[k] = SINE_W'(s);
        end
        return rom;
    endfunction

endpackage

// ===== hw/rtl/sprite_quad_vertex_setup_top.sv =====
// Top level of the sprite quad vertex setup: quad front end, corner sequencer, rotation.
`timescale 1ns / 1ps

// Sprite quad vertex setup.
//
// Command channel: a quad transaction is taken at a rising edge where start
// is high and busy is low. All quad fields are sampled at that edge.
// Result channel: each vertex is on the o_ ports for exactly one cycle while
// o_valid is high. A quad gives four vertices in consecutive cycles, in the
// order top-left, top-right, bottom-right, bottom-left; o_last marks the
// fourth. The receiver cannot hold results off and there is no backpressure.
//
// Path: the first vertex of a quad passes two quad stages, the corner
// sequencer and three rotation stages, all registered, before it is on
// the outputs; the other vertices of the quad follow it in order.
// Throughput: the corner sequencer hands one vertex per cycle to the rotation
// pipeline and takes the next quad at its last corner. Quads can be offered
// back to back; busy rises once the two quad stages are full behind a quad
// still being sequenced, and drops when the sequencer takes the next one.
//
// Reset (synchronous, active low) empties every stage; no vertex is produced
// for a quad that was in flight. The sine table is a fixed ROM.

module sprite_quad_vertex_setup_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sqvs_pkg::COORD_W-1:0] i_dest_x,
    input  logic signed [sqvs_pkg::COORD_W-1:0] i_dest_y,
    input  logic signed [sqvs_pkg::COORD_W-1:0] i_dest_w,
    input  logic signed [sqvs_pkg::COORD_W-1:0] i_dest_h,
    input  logic signed [sqvs_pkg::COORD_W-1:0] i_pivot_x,
    input  logic signed [sqvs_pkg::COORD_W-1:0] i_pivot_y,
    input  logic [15:0]                        i_angle,
    input  logic [63:0]                        i_src_rect,
    input  logic [47:0]                        i_tex_recip,
    input  logic [31:0]                        i_tint,
    input  logic signed [sqvs_pkg::DEPTH_W-1:0] i_depth_in,
    input  logic [sqvs_pkg::SLOT_W-1:0]        i_slot_in,
    output logic                               o_valid,
    output logic signed [sqvs_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [sqvs_pkg::COORD_W-1:0] o_pos_y,
    output logic signed [sqvs_pkg::DEPTH_W-1:0] o_depth_out,
    output logic [sqvs_pkg::COLOR_W-1:0]       o_red,
    output logic [sqvs_pkg::COLOR_W-1:0]       o_green,
    output logic [sqvs_pkg::COLOR_W-1:0]       o_blue,
    output logic [sqvs_pkg::COLOR_W-1:0]       o_alpha,
    output logic [sqvs_pkg::TEX_W-1:0]         o_tex_u,
    output logic [sqvs_pkg::TEX_W-1:0]         o_tex_v,
    output logic [sqvs_pkg::SLOT_W-1:0]        o_slot_out,
    output logic                               o_last
);
    import sqvs_pkg::*;

    // Corner order of the vertex stream
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    localparam int TEXEL_W = 17;          // src edge x+w fits in 17 bits
    localparam int RECIP_W = 24;
    localparam int TPROD_W = TEXEL_W + RECIP_W;
    localparam int TRND_W  = TPROD_W + 1;
    localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(65536);

    localparam t_sine_rom SINE_ROM = f_build_sine();

    // Round Q.24 texel products to Q.16 (half up) and saturate.
    function automatic logic [TEX_W-1:0] f_tex_round(input logic [TPROD_W-1:0] p);
        logic [TRND_W-1:0] t;
        t = (TRND_W'(p) + TRND_W'(128)) >> 8;
        if (t > TRND_W'(262143)) begin
            return TEX_W'(262143);
        end
        return TEX_W'(t);
    endfunction

    // ------------------------------------------------------------------
    // Handshake. Stage 1 and stage 2 hold whole quads and advance as a
    // ready chain behind the corner sequencer, which takes a new quad when
    // it is empty or emitting its last corner.
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_seq_valid;
    logic [1:0] r_cnt;
    logic w_take_quad, w_s2_rdy, w_s1_rdy, w_accept;

    assign w_take_quad = !r_seq_valid || (r_cnt == CORNER_BL);
    assign w_s2_rdy    = !r_s2_valid || w_take_quad;
    assign w_s1_rdy    = !r_s1_valid || w_s2_rdy;
    assign w_accept    = start && w_s1_rdy;
    assign busy        = !w_s1_rdy;

    // ------------------------------------------------------------------
    // Stage 1: registered quad transaction.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_s1_dx, r_s1_dy, r_s1_dw, r_s1_dh, r_s1_px, r_s1_py;
    logic [15:0]               r_s1_angle;
    logic [63:0]               r_s1_rect;
    logic [47:0]               r_s1_recip;
    logic [31:0]               r_s1_tint;
    logic signed [DEPTH_W-1:0] r_s1_depth;
    logic [SLOT_W-1:0]         r_s1_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_rdy) begin
            r_s1_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_dx    <= i_dest_x;
            r_s1_dy    <= i_dest_y;
            r_s1_dw    <= i_dest_w;
            r_s1_dh    <= i_dest_h;
            r_s1_px    <= i_pivot_x;
            r_s1_py    <= i_pivot_y;
            r_s1_angle <= i_angle;
            r_s1_rect  <= i_src_rect;
            r_s1_recip <= i_tex_recip;
            r_s1_tint  <= i_tint;
            r_s1_depth <= i_depth_in;
            r_s1_slot  <= i_slot_in;
        end
    end

    // Stage 1 logic: sine table addresses and texel products.
    // Cosine is the sine one quadrant on, so both share the phase index.
    logic [1:0]              w_quad;
    logic [PHASE_PROD_W-1:0] w_phase;
    logic [SIN_IDX_W-1:0]    w_ia, w_ia_mirror, w_sin_idx, w_cos_idx;
    logic                    w_sin_neg, w_cos_neg;
    logic [TEXEL_W-1:0]      w_u0, w_u1, w_v0, w_v1;
    logic [RECIP_W-1:0]      w_rw, w_rh;
    logic [SLOT_W-1:0]       w_slot;

    assign w_quad      = r_s1_angle[15:14];
    assign w_phase     = PHASE_PROD_W'(r_s1_angle[13:0]) * PHASE_PROD_W'(SINE_TABLE_DEPTH);
    assign w_ia        = SIN_IDX_W'(w_phase >> 14);
    assign w_ia_mirror = SIN_IDX_W'(SINE_TABLE_DEPTH) - w_ia;
    assign w_sin_idx   = w_quad[0] ? w_ia_mirror : w_ia;
    assign w_cos_idx   = w_quad[0] ? w_ia : w_ia_mirror;
    assign w_sin_neg   = w_quad[1];
    assign w_cos_neg   = w_quad[1] ^ w_quad[0];

    assign w_u0 = TEXEL_W'(r_s1_rect[15:0]);
    assign w_v0 = TEXEL_W'(r_s1_rect[31:16]);
    assign w_u1 = TEXEL_W'(r_s1_rect[15:0]) + TEXEL_W'(r_s1_rect[47:32]);
    assign w_v1 = TEXEL_W'(r_s1_rect[31:16]) + TEXEL_W'(r_s1_rect[63:48]);
    assign w_rw = r_s1_recip[23:0];
    assign w_rh = r_s1_recip[47:24];

    always_comb begin
        if (32'(r_s1_slot) >= TEXTURE_SLOTS) begin
            w_slot = SLOT_W'(TEXTURE_SLOTS - 1);
        end else begin
            w_slot = r_s1_slot;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: table read data and texel products.
    // ------------------------------------------------------------------
    logic [SINE_W-1:0]         r_s2_sin_mag, r_s2_cos_mag;
    logic                      r_s2_sin_neg, r_s2_cos_neg;
    logic [TPROD_W-1:0]        r_s2_pu0, r_s2_pu1, r_s2_pv0, r_s2_pv1;
    logic signed [COORD_W-1:0] r_s2_dx, r_s2_dy, r_s2_dw, r_s2_dh, r_s2_px, r_s2_py;
    logic [31:0]               r_s2_tint;
    logic signed [DEPTH_W-1:0] r_s2_depth;
    logic [SLOT_W-1:0]         r_s2_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_rdy) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_rdy && r_s1_valid) begin
            r_s2_sin_mag <= SINE_ROM[w_sin_idx];
            r_s2_cos_mag <= SINE_ROM[w_cos_idx];
            r_s2_sin_neg <= w_sin_neg;
            r_s2_cos_neg <= w_cos_neg;
            r_s2_pu0     <= TPROD_W'(w_u0) * TPROD_W'(w_rw);
            r_s2_pu1     <= TPROD_W'(w_u1) * TPROD_W'(w_rw);
            r_s2_pv0     <= TPROD_W'(w_v0) * TPROD_W'(w_rh);
            r_s2_pv1     <= TPROD_W'(w_v1) * TPROD_W'(w_rh);
            r_s2_dx      <= r_s1_dx;
            r_s2_dy      <= r_s1_dy;
            r_s2_dw      <= r_s1_dw;
            r_s2_dh      <= r_s1_dh;
            r_s2_px      <= r_s1_px;
            r_s2_py      <= r_s1_py;
            r_s2_tint    <= r_s1_tint;
            r_s2_depth   <= r_s1_depth;
            r_s2_slot    <= w_slot;
        end
    end

    // Stage 2 logic: signed trig, corner offsets, texture edges.
    logic signed [TRIG_W-1:0] n_sin, n_cos;
    logic signed [LOC_W-1:0]  n_lx0, n_lx1, n_ly0, n_ly1;
    logic [TEX_W-1:0]         n_umin, n_umax, n_vmin, n_vmax;

    assign n_sin = r_s2_sin_neg ? -$signed({1'b0, r_s2_sin_mag})
                                :  $signed({1'b0, r_s2_sin_mag});
    assign n_cos = r_s2_cos_neg ? -$signed({1'b0, r_s2_cos_mag})
                                :  $signed({1'b0, r_s2_cos_mag});

    assign n_lx0 = -LOC_W'(r_s2_px);
    assign n_ly0 = -LOC_W'(r_s2_py);
    assign n_lx1 = LOC_W'(r_s2_dw) - LOC_W'(r_s2_px);
    assign n_ly1 = LOC_W'(r_s2_dh) - LOC_W'(r_s2_py);

    // Untextured quads map the full 0..1 range.
    always_comb begin
        if (r_s2_slot == '0) begin
            n_umin = '0;
            n_vmin = '0;
            n_umax = TEX_ONE;
            n_vmax = TEX_ONE;
        end else begin
            n_umin = f_tex_round(r_s2_pu0);
            n_vmin = f_tex_round(r_s2_pv0);
            n_umax = f_tex_round(r_s2_pu1);
            n_vmax = f_tex_round(r_s2_pv1);
        end
    end

    // ------------------------------------------------------------------
    // Corner sequencer: holds one quad and steps through its corners.
    // ------------------------------------------------------------------
    logic signed [TRIG_W-1:0]  r_q_sin, r_q_cos;
    logic signed [LOC_W-1:0]   r_q_lx0, r_q_lx1, r_q_ly0, r_q_ly1;
    logic signed [COORD_W-1:0] r_q_dx, r_q_dy;
    logic [TEX_W-1:0]          r_q_umin, r_q_umax, r_q_vmin, r_q_vmax;
    logic [31:0]               r_q_tint;
    logic signed [DEPTH_W-1:0] r_q_depth;
    logic [SLOT_W-1:0]         r_q_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_valid <= 1'b0;
            r_cnt       <= CORNER_TL;
        end else if (w_take_quad) begin
            r_seq_valid <= r_s2_valid;
            r_cnt       <= CORNER_TL;
        end else begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_quad && r_s2_valid) begin
            r_q_sin   <= n_sin;
            r_q_cos   <= n_cos;
            r_q_lx0   <= n_lx0;
            r_q_lx1   <= n_lx1;
            r_q_ly0   <= n_ly0;
            r_q_ly1   <= n_ly1;
            r_q_dx    <= r_s2_dx;
            r_q_dy    <= r_s2_dy;
            r_q_umin  <= n_umin;
            r_q_umax  <= n_umax;
            r_q_vmin  <= n_vmin;
            r_q_vmax  <= n_vmax;
            r_q_tint  <= r_s2_tint;
            r_q_depth <= r_s2_depth;
            r_q_slot  <= r_s2_slot;
        end
    end

    logic signed [LOC_W-1:0] w_lx, w_ly;
    t_vtx_attr               w_attr;

    always_comb begin
        w_attr.depth = r_q_depth;
        // byte * 257 is the byte repeated in both halves
        w_attr.red   = {r_q_tint[7:0],   r_q_tint[7:0]};
        w_attr.green = {r_q_tint[15:8],  r_q_tint[15:8]};
        w_attr.blue  = {r_q_tint[23:16], r_q_tint[23:16]};
        w_attr.alpha = {r_q_tint[31:24], r_q_tint[31:24]};
        w_attr.slot  = r_q_slot;
        w_attr.last  = 1'b0;
        case (r_cnt)
            CORNER_TL: begin
                w_lx         = r_q_lx0;
                w_ly         = r_q_ly0;
                w_attr.tex_u = r_q_umin;
                w_attr.tex_v = r_q_vmin;
            end
            CORNER_TR: begin
                w_lx         = r_q_lx1;
                w_ly         = r_q_ly0;
                w_attr.tex_u = r_q_umax;
                w_attr.tex_v = r_q_vmin;
            end
            CORNER_BR: begin
                w_lx         = r_q_lx1;
                w_ly         = r_q_ly1;
                w_attr.tex_u = r_q_umax;
                w_attr.tex_v = r_q_vmax;
            end
            default: begin
                w_lx         = r_q_lx0;
                w_ly         = r_q_ly1;
                w_attr.tex_u = r_q_umin;
                w_attr.tex_v = r_q_vmax;
                w_attr.last  = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Rotation pipeline, ending in the output register.
    // ------------------------------------------------------------------
    t_vtx_attr w_out_attr;

    sqvs_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_seq_valid),
        .i_lx    (w_lx),
        .i_ly    (w_ly),
        .i_sin   (r_q_sin),
        .i_cos   (r_q_cos),
        .i_dx    (r_q_dx),
        .i_dy    (r_q_dy),
        .i_attr  (w_attr),
        .o_valid (o_valid),
        .o_pos_x (o_pos_x),
        .o_pos_y (o_pos_y),
        .o_attr  (w_out_attr)
    );

    assign o_depth_out = w_out_attr.depth;
    assign o_red       = w_out_attr.red;
    assign o_green     = w_out_attr.green;
    assign o_blue      = w_out_attr.blue;
    assign o_alpha     = w_out_attr.alpha;
    assign o_tex_u     = w_out_attr.tex_u;
    assign o_tex_v     = w_out_attr.tex_v;
    assign o_slot_out  = w_out_attr.slot;
    assign o_last      = w_out_attr.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_s1_valid)
        else $error("accepted quad did not reach stage 1");

    a_busy_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_s1_valid && r_s2_valid && r_seq_valid))
        else $error("busy raised with room in the quad stages");

    a_corner_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_valid && (r_cnt != CORNER_BL)) |=>
            (r_seq_valid && (r_cnt == $past(r_cnt) + 2'd1)))
        else $error("corner sequencer skipped or dropped a corner");

    a_vertex_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("vertex run of a quad broken before its last corner");

    a_last_after_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |->
            ($past(o_valid, 1) && $past(o_valid, 2) && $past(o_valid, 3) &&
             !$past(o_last, 1) && !$past(o_last, 2) && !$past(o_last, 3)))
        else $error("last vertex not preceded by three corners");

endmodule

// ===== hw/rtl/sqvs_rotate.sv =====
// Three-stage corner rotation: products, rounded sums, destination add with saturation.
`timescale 1ns / 1ps

module sqvs_rotate (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [sqvs_pkg::LOC_W-1:0]   i_lx,
    input  logic signed [sqvs_pkg::LOC_W-1:0]   i_ly,
    input  logic signed [sqvs_pkg::TRIG_W-1:0]  i_sin,
    input  logic signed [sqvs_pkg::TRIG_W-1:0]  i_cos,
    input  logic signed [sqvs_pkg::COORD_W-1:0] i_dx,
    input  logic signed [sqvs_pkg::COORD_W-1:0] i_dy,
    input  sqvs_pkg::t_vtx_attr              i_attr,
    output logic                             o_valid,
    output logic signed [sqvs_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [sqvs_pkg::COORD_W-1:0] o_pos_y,
    output sqvs_pkg::t_vtx_attr              o_attr
);
    import sqvs_pkg::*;

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(8388608);

    // Stage 1: four products
    logic                      r_m_valid;
    logic signed [PROD_W-1:0]  r_xc, r_ys, r_xs, r_yc;
    logic signed [COORD_W-1:0] r_m_dx, r_m_dy;
    t_vtx_attr                 r_m_attr;

    // Stage 2: rotated offsets in Q.8
    logic                      r_r_valid;
    logic signed [ROT_W-1:0]   r_rx, r_ry;
    logic signed [COORD_W-1:0] r_r_dx, r_r_dy;
    t_vtx_attr                 r_r_attr;

    // Stage 3: output register
    logic                      r_o_valid;
    logic signed [COORD_W-1:0] r_o_x, r_o_y;
    t_vtx_attr                 r_o_attr;

    logic signed [ACC_W-1:0]   w_acc_x, w_acc_y;
    logic signed [SUM_W-1:0]   w_sum_x, w_sum_y;
    logic signed [COORD_W-1:0] n_x, n_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
            r_r_valid <= r_m_valid;
            r_o_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xc     <= PROD_W'(i_lx) * PROD_W'(i_cos);
        r_ys     <= PROD_W'(i_ly) * PROD_W'(i_sin);
        r_xs     <= PROD_W'(i_lx) * PROD_W'(i_sin);
        r_yc     <= PROD_W'(i_ly) * PROD_W'(i_cos);
        r_m_dx   <= i_dx;
        r_m_dy   <= i_dy;
        r_m_attr <= i_attr;
    end

    // Round half up from Q.24 to Q.8: floor((v + 2^15) / 2^16)
    assign w_acc_x = ACC_W'(r_xc) - ACC_W'(r_ys) + ACC_W'(32768);
    assign w_acc_y = ACC_W'(r_xs) + ACC_W'(r_yc) + ACC_W'(32768);

    always_ff @(posedge i_clk) begin
        r_rx     <= ROT_W'(w_acc_x >>> 16);
        r_ry     <= ROT_W'(w_acc_y >>> 16);
        r_r_dx   <= r_m_dx;
        r_r_dy   <= r_m_dy;
        r_r_attr <= r_m_attr;
    end

    assign w_sum_x = SUM_W'(r_r_dx) + SUM_W'(r_rx);
    assign w_sum_y = SUM_W'(r_r_dy) + SUM_W'(r_ry);

    always_comb begin
        if (w_sum_x > POS_MAX) begin
            n_x = COORD_W'(POS_MAX);
        end else if (w_sum_x < POS_MIN) begin
            n_x = COORD_W'(POS_MIN);
        end else begin
            n_x = COORD_W'(w_sum_x);
        end
        if (w_sum_y > POS_MAX) begin
            n_y = COORD_W'(POS_MAX);
        end else if (w_sum_y < POS_MIN) begin
            n_y = COORD_W'(POS_MIN);
        end else begin
            n_y = COORD_W'(w_sum_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_x    <= n_x;
        r_o_y    <= n_y;
        r_o_attr <= r_r_attr;
    end

    assign o_valid = r_o_valid;
    assign o_pos_x = r_o_x;
    assign o_pos_y = r_o_y;
    assign o_attr  = r_o_attr;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sprite quad vertex setup block.
`timescale 1ns / 1ps

import sqvs_pkg::*;

// Q16.8 position range, used by the predictor's saturation
localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));
localparam longint TEX_MAX   = (longint'(1) << TEX_W) - 1;
localparam longint ONE_Q16   = 65536;

// One quad as offered on the command ports
typedef struct {
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dw;
    logic signed [COORD_W-1:0] dh;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [15:0]               angle;
    logic [63:0]               src_rect;
    logic [47:0]               recip;
    logic [31:0]               tint;
    logic signed [DEPTH_W-1:0] depth;
    logic [SLOT_W-1:0]         slot;
} t_quad;

// One vertex as seen on the result ports
typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    t_vtx_attr                 attr;
} t_vertex;

// Predicts the four vertices of each accepted quad and checks them in order.
class vertex_scoreboard;
    longint unsigned quarter_sine[SINE_TABLE_DEPTH + 1];
    t_vertex         expected_vertices[$];
    int              mismatches;
    int              vertices_checked;

    function new();
        longint unsigned theta;
        longint unsigned term;
        longint unsigned rounded;
        longint          acc;
        int              k;
        int              n;
        mismatches       = 0;
        vertices_checked = 0;
        // Quarter-wave sine, Q1.16, Taylor series in Q30 with truncated terms
        for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            theta = (HALF_PI_Q30 * longint'(k)) / longint'(SINE_TABLE_DEPTH);
            term  = theta;
            acc   = longint'(theta);
            for (n = 1; n <= 7; n++) begin
                term = ((((term * theta) >> 30) * theta) >> 30) /
                       longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            rounded = (longint'(acc) + 8192) >> 14;
            if (rounded > ONE_Q16) begin
                rounded = ONE_Q16;
            end
            quarter_sine[k] = rounded;
        end
    endfunction

    function longint sine_at(logic [15:0] a);
        int     idx;
        longint mag;
        idx = (int'(a[13:0]) * SINE_TABLE_DEPTH) >> 14;
        if (idx > SINE_TABLE_DEPTH) begin
            idx = SINE_TABLE_DEPTH;
        end
        if (a[14]) begin
            idx = SINE_TABLE_DEPTH - idx;
        end
        mag = longint'(quarter_sine[idx]);
        return a[15] ? -mag : mag;
    endfunction

    // Q.24 -> Q.8, round half toward +inf
    function longint round_to_q8(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > COORD_MAX) begin
            return COORD_W'(COORD_MAX);
        end
        if (v < COORD_MIN) begin
            return COORD_W'(COORD_MIN);
        end
        return COORD_W'(v);
    endfunction

    function logic [TEX_W-1:0] tex_scale(logic [16:0] texels, logic [23:0] recip);
        longint unsigned p;
        p = (longint'(texels) * longint'(recip) + 128) >> 8;
        return (p > TEX_MAX) ? TEX_W'(TEX_MAX) : TEX_W'(p);
    endfunction

    function void add_quad(t_quad q);
        longint            s;
        longint            c;
        longint            lx[4];
        longint            ly[4];
        logic [TEX_W-1:0]  u_lo;
        logic [TEX_W-1:0]  u_hi;
        logic [TEX_W-1:0]  v_lo;
        logic [TEX_W-1:0]  v_hi;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       sx;
        logic [15:0]       sy;
        logic [15:0]       sw;
        logic [15:0]       sh;
        t_vertex           vtx;
        int                k;
        s = sine_at(q.angle);
        c = sine_at(q.angle + 16'd16384);

        lx[0] = -longint'(q.px);
        lx[1] = longint'(q.dw) - longint'(q.px);
        lx[2] = lx[1];
        lx[3] = lx[0];
        ly[0] = -longint'(q.py);
        ly[1] = ly[0];
        ly[2] = longint'(q.dh) - longint'(q.py);
        ly[3] = ly[2];

        slot = q.slot;
        if (int'(slot) >= TEXTURE_SLOTS) begin
            slot = SLOT_W'(TEXTURE_SLOTS - 1);
        end

        if (slot == '0) begin
            // untextured: full 0..1 span
            u_lo = '0;
            v_lo = '0;
            u_hi = TEX_W'(ONE_Q16);
            v_hi = TEX_W'(ONE_Q16);
        end else begin
            sx   = q.src_rect[15:0];
            sy   = q.src_rect[31:16];
            sw   = q.src_rect[47:32];
            sh   = q.src_rect[63:48];
            u_lo = tex_scale({1'b0, sx}, q.recip[23:0]);
            v_lo = tex_scale({1'b0, sy}, q.recip[47:24]);
            u_hi = tex_scale({1'b0, sx} + {1'b0, sw}, q.recip[23:0]);
            v_hi = tex_scale({1'b0, sy} + {1'b0, sh}, q.recip[47:24]);
        end

        for (k = 0; k < 4; k++) begin
            vtx.pos_x      = clamp_coord(longint'(q.dx) + round_to_q8(lx[k] * c - ly[k] * s));
            vtx.pos_y      = clamp_coord(longint'(q.dy) + round_to_q8(lx[k] * s + ly[k] * c));
            vtx.attr.depth = q.depth;
            vtx.attr.red   = 16'(q.tint[7:0]) * 16'd257;
            vtx.attr.green = 16'(q.tint[15:8]) * 16'd257;
            vtx.attr.blue  = 16'(q.tint[23:16]) * 16'd257;
            vtx.attr.alpha = 16'(q.tint[31:24]) * 16'd257;
            vtx.attr.tex_u = (k == 1 || k == 2) ? u_hi : u_lo;
            vtx.attr.tex_v = (k >= 2) ? v_hi : v_lo;
            vtx.attr.slot  = slot;
            vtx.attr.last  = (k == 3);
            expected_vertices = {expected_vertices, vtx};
        end
    endfunction

    function void compare_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", fname, exp_v, act_v);
            mismatches++;
        end
    endfunction

    function void check_vertex(t_vertex got);
        t_vertex want;
        if (expected_vertices.size() == 0) begin
            $error("vertex with no quad outstanding: x %0h y %0h", got.pos_x, got.pos_y);
            mismatches++;
            return;
        end
        want = expected_vertices.pop_front();
        vertices_checked++;
        compare_field("pos_x", want.pos_x, got.pos_x);
        compare_field("pos_y", want.pos_y, got.pos_y);
        compare_field("depth_out", want.attr.depth, got.attr.depth);
        compare_field("red", want.attr.red, got.attr.red);
        compare_field("green", want.attr.green, got.attr.green);
        compare_field("blue", want.attr.blue, got.attr.blue);
        compare_field("alpha", want.attr.alpha, got.attr.alpha);
        compare_field("tex_u", want.attr.tex_u, got.attr.tex_u);
        compare_field("tex_v", want.attr.tex_v, got.attr.tex_v);
        compare_field("slot_out", want.attr.slot, got.attr.slot);
        compare_field("last", want.attr.last, got.attr.last);
    endfunction

    function int pending();
        return expected_vertices.size();
    endfunction
endclass

module tb_top;

    // Clock, reset and command side
    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] i_dest_x;
    logic signed [COORD_W-1:0] i_dest_y;
    logic signed [COORD_W-1:0] i_dest_w;
    logic signed [COORD_W-1:0] i_dest_h;
    logic signed [COORD_W-1:0] i_pivot_x;
    logic signed [COORD_W-1:0] i_pivot_y;
    logic [15:0]               i_angle;
    logic [63:0]               i_src_rect;
    logic [47:0]               i_tex_recip;
    logic [31:0]               i_tint;
    logic signed [DEPTH_W-1:0] i_depth_in;
    logic [SLOT_W-1:0]         i_slot_in;

    // Vertex side
    logic                      o_valid;
    logic signed [COORD_W-1:0] o_pos_x;
    logic signed [COORD_W-1:0] o_pos_y;
    logic signed [DEPTH_W-1:0] o_depth_out;
    logic [COLOR_W-1:0]        o_red;
    logic [COLOR_W-1:0]        o_green;
    logic [COLOR_W-1:0]        o_blue;
    logic [COLOR_W-1:0]        o_alpha;
    logic [TEX_W-1:0]          o_tex_u;
    logic [TEX_W-1:0]          o_tex_v;
    logic [SLOT_W-1:0]         o_slot_out;
    logic                      o_last;

    vertex_scoreboard sb;
    t_vertex          seen_vertex;
    int               quads_sent;
    int               directed_quads;

    // Angles for the directed quadrant checks
    logic [15:0] a_list[7] = '{16'd16384, 16'd32768, 16'd49152, 16'd65535,
                               16'd16383, 16'd16385, 16'd1};

    sprite_quad_vertex_setup_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_dest_x    (i_dest_x),
        .i_dest_y    (i_dest_y),
        .i_dest_w    (i_dest_w),
        .i_dest_h    (i_dest_h),
        .i_pivot_x   (i_pivot_x),
        .i_pivot_y   (i_pivot_y),
        .i_angle     (i_angle),
        .i_src_rect  (i_src_rect),
        .i_tex_recip (i_tex_recip),
        .i_tint      (i_tint),
        .i_depth_in  (i_depth_in),
        .i_slot_in   (i_slot_in),
        .o_valid     (o_valid),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_depth_out (o_depth_out),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha     (o_alpha),
        .o_tex_u     (o_tex_u),
        .o_tex_v     (o_tex_v),
        .o_slot_out  (o_slot_out),
        .o_last      (o_last)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Vertex monitor: no backpressure exists, every strobed cycle is one transaction.
    // Sampled at the rising edge, before the block's registers move.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            seen_vertex.pos_x      = o_pos_x;
            seen_vertex.pos_y      = o_pos_y;
            seen_vertex.attr.depth = o_depth_out;
            seen_vertex.attr.red   = o_red;
            seen_vertex.attr.green = o_green;
            seen_vertex.attr.blue  = o_blue;
            seen_vertex.attr.alpha = o_alpha;
            seen_vertex.attr.tex_u = o_tex_u;
            seen_vertex.attr.tex_v = o_tex_v;
            seen_vertex.attr.slot  = o_slot_out;
            seen_vertex.attr.last  = o_last;
            sb.check_vertex(seen_vertex);
        end
    end

    // Quad driver. Inputs move only at falling edges; the transaction is taken
    // at the first rising edge with start high and busy low. Before the quad,
    // the sender idles each cycle with probability idle_pct percent.
    task automatic send_quad(input t_quad q, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start       = 1'b1;
        i_dest_x    = q.dx;
        i_dest_y    = q.dy;
        i_dest_w    = q.dw;
        i_dest_h    = q.dh;
        i_pivot_x   = q.px;
        i_pivot_y   = q.py;
        i_angle     = q.angle;
        i_src_rect  = q.src_rect;
        i_tex_recip = q.recip;
        i_tint      = q.tint;
        i_depth_in  = q.depth;
        i_slot_in   = q.slot;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0) begin
                break;
            end
        end
        sb.add_quad(q);
        quads_sent++;
    endtask

    // Drop start and hold off until every predicted vertex has come out
    task automatic wait_vertices_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Plain textured quad around a modest position
    function automatic t_quad plain_quad();
        t_quad q;
        q.dx       = 24'sd25600;        // 100.0
        q.dy       = 24'sd12800;        // 50.0
        q.dw       = 24'sd8192;         // 32.0
        q.dh       = 24'sd4096;         // 16.0
        q.px       = 24'sd4096;
        q.py       = 24'sd2048;
        q.angle    = '0;
        q.src_rect = {16'd16, 16'd32, 16'd8, 16'd4};
        q.recip    = {24'd65536, 24'd131072};   // 1/256 and 1/128
        q.tint     = 32'h80C0_4020;
        q.depth    = 16'sd7;
        q.slot     = 3'd1;
        return q;
    endfunction

    // Random quad: mostly sprite-sized, a quarter with geometry and texture fields fully random
    function automatic t_quad random_quad();
        t_quad q;
        int    wide;
        wide = ($urandom_range(0, 3) == 0);
        if (wide) begin
            q.dx       = COORD_W'($urandom);
            q.dy       = COORD_W'($urandom);
            q.dw       = COORD_W'($urandom);
            q.dh       = COORD_W'($urandom);
            q.px       = COORD_W'($urandom);
            q.py       = COORD_W'($urandom);
            q.src_rect = {$urandom, $urandom};
            q.recip    = {16'($urandom), $urandom};
        end else begin
            q.dx       = COORD_W'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
            q.dy       = COORD_W'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
            q.dw       = COORD_W'(int'($urandom_range(0, 2 ** 16)) - 2 ** 14);
            q.dh       = COORD_W'(int'($urandom_range(0, 2 ** 16)) - 2 ** 14);
            q.px       = COORD_W'(int'($urandom_range(0, 2 ** 15)) - 2 ** 13);
            q.py       = COORD_W'(int'($urandom_range(0, 2 ** 15)) - 2 ** 13);
            q.src_rect = {16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                          16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023))};
            q.recip    = {24'($urandom_range(0, 2 ** 16)), 24'($urandom_range(0, 2 ** 16))};
        end
        // Quadrant boundaries now and then, otherwise any angle
        q.angle = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3) * 16384) : 16'($urandom);
        q.tint  = $urandom;
        q.depth = DEPTH_W'($urandom);
        q.slot  = SLOT_W'($urandom_range(0, 7));
        return q;
    endfunction

    // Directed quads: quadrants, rounding, saturation, texture edge cases, field extremes
    task automatic run_directed();
        t_quad q;
        int    a;
        // untextured, angle zero, all-zero tint
        q      = plain_quad();
        q.slot = '0;
        q.tint = '0;
        send_quad(q, 0);
        // each quadrant boundary, the last angle step, an index near the top of the table
        foreach (a_list[i]) begin
            q       = plain_quad();
            q.angle = a_list[i];
            send_quad(q, 0);
        end
        // 45 degrees with odd offsets, lands on rounding ties and non-ties
        q       = plain_quad();
        q.angle = 16'd8192;
        q.px    = 24'sd1;
        q.py    = -24'sd3;
        q.dw    = 24'sd257;
        q.dh    = 24'sd511;
        send_quad(q, 0);
        // texture coordinates saturate, 17-bit edge sums
        q          = plain_quad();
        q.slot     = 3'd7;
        q.src_rect = '1;
        q.recip    = '1;
        send_quad(q, 0);
        // textured with zero reciprocals
        q          = plain_quad();
        q.slot     = 3'd3;
        q.src_rect = '0;
        q.recip    = '0;
        send_quad(q, 0);
        // colour and depth extremes
        q       = plain_quad();
        q.tint  = '1;
        q.depth = 16'sh7FFF;
        send_quad(q, 0);
        q       = plain_quad();
        q.tint  = 32'h80FF_017F;
        q.depth = 16'sh8000;
        q.slot  = 3'd4;
        send_quad(q, 0);
        // positions saturate high
        q    = plain_quad();
        q.dx = 24'sh7FFFFF;
        q.dy = 24'sh7FFFFF;
        q.dw = 24'sh7FFFFF;
        q.dh = 24'sh7FFFFF;
        q.px = 24'sh800000;
        q.py = 24'sh800000;
        send_quad(q, 0);
        // positions saturate low
        q    = plain_quad();
        q.dx = 24'sh800000;
        q.dy = 24'sh800000;
        q.dw = 24'sh800000;
        q.dh = 24'sh800000;
        q.px = 24'sh7FFFFF;
        q.py = 24'sh7FFFFF;
        send_quad(q, 0);
        // extreme sizes under rotation
        for (a = 0; a < 3; a++) begin
            q       = plain_quad();
            q.dx    = (a == 0) ? 24'sh800000 : 24'sh7FFFFF;
            q.dy    = (a == 1) ? 24'sh800000 : 24'sh7FFFFF;
            q.dw    = (a == 2) ? 24'sh800000 : 24'sh7FFFFF;
            q.dh    = 24'sh7FFFFF;
            q.px    = 24'sh800000;
            q.py    = 24'sh7FFFFF;
            q.angle = 16'(8192 + a * 16384);
            send_quad(q, 0);
        end
        // mirrored quad with the pivot at its center
        q    = plain_quad();
        q.dw = -24'sd8192;
        q.dh = -24'sd4096;
        q.px = -24'sd4096;
        q.py = -24'sd2048;
        q.angle = 16'd40000;
        send_quad(q, 0);
        // pivot well outside the quad
        q       = plain_quad();
        q.px    = 24'sd500000;
        q.py    = -24'sd700000;
        q.angle = 16'd21845;
        send_quad(q, 0);
    endtask

    // Main sequence
    initial begin
        int idle_pct[4];
        int ph;
        int n;

        // only the sender can idle: none, sparse, none, light
        idle_pct[0]    = 0;
        idle_pct[1]    = 82;
        idle_pct[2]    = 0;
        idle_pct[3]    = 18;
        sb             = new();
        quads_sent     = 0;
        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_dest_x       = '0;
        i_dest_y       = '0;
        i_dest_w       = '0;
        i_dest_h       = '0;
        i_pivot_x      = '0;
        i_pivot_y      = '0;
        i_angle        = '0;
        i_src_rect     = '0;
        i_tex_recip    = '0;
        i_tint         = '0;
        i_depth_in     = '0;
        i_slot_in      = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed quads back to back, so busy gets exercised
        run_directed();
        directed_quads = quads_sent;
        wait_vertices_drained();

        // random phases, each followed by a full drain
        for (ph = 0; ph < 4; ph++) begin
            for (n = 0; n < 50; n++) begin
                send_quad(random_quad(), idle_pct[ph]);
            end
            wait_vertices_drained();
        end

        // tail: let anything stray surface
        repeat (16) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $error("%0d predicted vertices never came out", sb.pending());
            sb.mismatches++;
        end

        $display("Run covered %0d quads (%0d directed, rest random) and %0d vertices,",
                 quads_sent, directed_quads, sb.vertices_checked);
        $display("  with back-to-back, sparse and light sender gaps and full drains.");
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
